FILE: rtl/core/alpha_aware_mip_downsample_core_macros.svh
// Assertion helpers for the downsampler's amds_scan module.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ALPHA_AWARE_MIP_DOWNSAMPLE_CORE_MACROS_SVH
`define ALPHA_AWARE_MIP_DOWNSAMPLE_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define AMDS_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/amds_pkg.sv
package amds_pkg;

  localparam int HEIGHT_LIMIT = 4096;
  localparam int RW           = $clog2(HEIGHT_LIMIT);
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CH_W         = 8;
  localparam int PAIR_W       = CH_W + 1;
  localparam int SUM_W        = CH_W + 2;

  // Divide-by-three as a reciprocal multiply with rounding.
  localparam int DIV3_MUL = 85;
  localparam int DIV3_RND = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1
  } cfg_idx_e;

  // Sums of the opaque texels of one horizontal pair and their count.
  typedef struct packed {
    logic [PAIR_W-1:0] r;
    logic [PAIR_W-1:0] g;
    logic [PAIR_W-1:0] b;
    logic [PAIR_W-1:0] a;
    logic [1:0]        k;
  } pair_t;

  // A completed pair on its way to the averaging stage.
  typedef struct packed {
    pair_t sum;
    logic  use_line;
    logic  frame_end;
  } blk_t;

  // Average of up to four opaque texels, selected by their count.
  function automatic logic [CH_W-1:0] avg(input logic [SUM_W-1:0] s, input logic [2:0] k);
    logic [16:0]      p;
    logic [SUM_W:0]   s1;
    logic [SUM_W-1:0] v;
    begin
      p  = 17'(s) * 17'(DIV3_MUL) + 17'(DIV3_RND);
      s1 = {1'b0, s};
      case (k)
        3'd1:    v = s;
        3'd2:    v = SUM_W'((s1 + (SUM_W+1)'(1)) >> 1);
        3'd3:    v = SUM_W'(p >> 8);
        3'd4:    v = SUM_W'((s1 + (SUM_W+1)'(2)) >> 2);
        default: v = '0;
      endcase
      return v[CH_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/alpha_aware_mip_downsample_core.sv
// Alpha-aware 2x2 mip downsampler. Source RGBA pixels arrive in raster order,
// one item per cycle unless stalled, and the half-size level leaves in raster
// order; each result averages only the texels of its 2x2 block whose alpha is
// non-zero (alpha included), and a block with no such texel comes out as
// transparent black. An odd width or height above one drops its last
// column or row, whose pixels are consumed without a result; a side of one
// keeps one output column or row. frame_end marks the last result of each
// reduced frame. src_width (index 0) and src_height (index 1) must be written
// only while the block is idle; the block itself does not enforce it. Each
// write restarts the frame at the origin, and values out of range saturate
// to 1..MAX_WIDTH and 1..4096. The sustained rate is one pixel per cycle
// while the output is not stalled, with no gaps at frame or row boundaries.
// A result passes through the hand-off register, loaded with the line buffer
// RAM read, to the averaging stage's output register. The line buffer is a
// single-port RAM of MAX_WIDTH/2 entries that holds the pair sums of an even
// row; the odd row reads them back at the same column, so a write and a read
// of one entry never overlap. The buffer needs no clearing pass after reset,
// since every entry is written before it is read. When the output is stalled,
// one more block waits in the hand-off register, then the input stalls.

module alpha_aware_mip_downsample_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [amds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [amds_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [amds_pkg::CH_W-1:0]      in_red_i,
  input  logic [amds_pkg::CH_W-1:0]      in_green_i,
  input  logic [amds_pkg::CH_W-1:0]      in_blue_i,
  input  logic [amds_pkg::CH_W-1:0]      in_alpha_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [amds_pkg::CH_W-1:0]      out_red_o,
  output logic [amds_pkg::CH_W-1:0]      out_green_o,
  output logic [amds_pkg::CH_W-1:0]      out_blue_o,
  output logic [amds_pkg::CH_W-1:0]      out_alpha_o,
  output logic                           frame_end_o
);

  // One line entry per horizontal pair of the widest source row.
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic            s1_pop;
  logic            s1_valid;
  amds_pkg::blk_t  s1_blk;
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  amds_pkg::pair_t mem_wdata;
  amds_pkg::pair_t mem_rdata;

  // Position counters, pair accumulator and the block hand-off register.
  amds_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .in_alpha_i  (in_alpha_i),
    .s1_pop_i    (s1_pop),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1_blk),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata)
  );

  // Even-row pair sums, read back by the odd row of the same block.
  amds_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Block sum, count-selected average and the output register.
  amds_resolve u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1_blk),
    .line_i      (mem_rdata),
    .s1_pop_o    (s1_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .frame_end_o (frame_end_o)
  );

endmodule

FILE: rtl/core/amds_line_mem.sv
module amds_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [AW-1:0]       addr_i,
  input  amds_pkg::pair_t     wdata_i,
  output amds_pkg::pair_t     rdata_o
);

  amds_pkg::pair_t mem [DEPTH];
  amds_pkg::pair_t rdata_q;

  // Single port: a write and a read never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/amds_scan.sv
`include "alpha_aware_mip_downsample_core_macros.svh"

module amds_scan #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [amds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [amds_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [amds_pkg::CH_W-1:0]     in_red_i,
  input  logic [amds_pkg::CH_W-1:0]     in_green_i,
  input  logic [amds_pkg::CH_W-1:0]     in_blue_i,
  input  logic [amds_pkg::CH_W-1:0]     in_alpha_i,
  input  logic                          s1_pop_i,
  output logic                          s1_valid_o,
  output amds_pkg::blk_t                s1_o,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_addr_o,
  output amds_pkg::pair_t               mem_wdata_o
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = amds_pkg::RW;
  localparam int PW = amds_pkg::PAIR_W;

  // Geometry derived from the registers at write time.
  logic [CW-1:0]   w_last_q, w_last_d;
  logic            w_drop_q, w_drop_d;
  logic [AW-1:0]   nx_last_q, nx_last_d;
  logic [RW-1:0]   h_last_q, h_last_d;
  logic            h_drop_q, h_drop_d;
  logic [RW-2:0]   ny_last_q, ny_last_d;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  amds_pkg::pair_t acc_q, acc_d;
  logic            s1_valid_q, s1_valid_d;
  amds_pkg::blk_t  s1_q, s1_d;

  logic [31:0]     w32, h32, nx32, ny32;
  logic            accept, opaque, col_last, row_last, active, complete, produce;
  logic [AW-1:0]   idx;
  amds_pkg::pair_t add, base, pair_new;

  always_comb begin
    w32 = 32'(cfg_wdata_i);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end
    h32 = 32'(cfg_wdata_i);
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(amds_pkg::HEIGHT_LIMIT)) begin
      h32 = 32'(amds_pkg::HEIGHT_LIMIT);
    end
    nx32 = (w32 > 32'd1) ? (w32 >> 1) : 32'd1;
    ny32 = (h32 > 32'd1) ? (h32 >> 1) : 32'd1;
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign opaque   = |in_alpha_i;
  assign col_last = (col_q == w_last_q);
  assign row_last = (row_q == h_last_q);
  // The last column of an odd width and the last row of an odd height drop out.
  assign active   = !(w_drop_q && col_last) && !(h_drop_q && row_last);
  assign complete = col_q[0] || col_last;
  assign produce  = active && complete && (row_q[0] || row_last);
  assign idx      = AW'(col_q >> 1);

  always_comb begin
    add.r = opaque ? PW'(in_red_i)   : '0;
    add.g = opaque ? PW'(in_green_i) : '0;
    add.b = opaque ? PW'(in_blue_i)  : '0;
    add.a = opaque ? PW'(in_alpha_i) : '0;
    add.k = {1'b0, opaque};
    base  = col_q[0] ? acc_q : '0;
    pair_new.r = base.r + add.r;
    pair_new.g = base.g + add.g;
    pair_new.b = base.b + add.b;
    pair_new.a = base.a + add.a;
    pair_new.k = base.k + add.k;
  end

  always_comb begin
    w_last_d  = w_last_q;
    w_drop_d  = w_drop_q;
    nx_last_d = nx_last_q;
    h_last_d  = h_last_q;
    h_drop_d  = h_drop_q;
    ny_last_d = ny_last_q;
    col_d     = col_q;
    row_d     = row_q;
    acc_d     = acc_q;
    if (accept) begin
      if (active) begin
        acc_d = pair_new;
      end
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    // A width or height write restarts the frame; the line buffer is left alone.
    if (cfg_we_i && (cfg_index_i == amds_pkg::CFG_SRC_WIDTH ||
                     cfg_index_i == amds_pkg::CFG_SRC_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
      acc_d = '0;
      if (cfg_index_i == amds_pkg::CFG_SRC_WIDTH) begin
        w_last_d  = CW'(w32 - 32'd1);
        w_drop_d  = w32[0] && (w32 != 32'd1);
        nx_last_d = AW'(nx32 - 32'd1);
      end else begin
        h_last_d  = RW'(h32 - 32'd1);
        h_drop_d  = h32[0] && (h32 != 32'd1);
        ny_last_d = (RW-1)'(ny32 - 32'd1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (accept && produce) begin
      s1_valid_d     = 1'b1;
      s1_d.sum       = pair_new;
      s1_d.use_line  = row_q[0];
      s1_d.frame_end = (idx == nx_last_q) && (row_q[RW-1:1] == ny_last_q);
    end else if (s1_pop_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= '0;
      w_drop_q   <= 1'b0;
      nx_last_q  <= '0;
      h_last_q   <= '0;
      h_drop_q   <= 1'b0;
      ny_last_q  <= '0;
      col_q      <= '0;
      row_q      <= '0;
      acc_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      w_last_q   <= w_last_d;
      w_drop_q   <= w_drop_d;
      nx_last_q  <= nx_last_d;
      h_last_q   <= h_last_d;
      h_drop_q   <= h_drop_d;
      ny_last_q  <= ny_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
      acc_q      <= acc_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // The line read lands in the RAM output register with the hand-off register
  // load of its block; no new pixel enters while that block waits.
  assign in_stall_o  = s1_valid_q && !s1_pop_i;
  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign mem_we_o    = accept && active && complete && !row_q[0] && !row_last;
  assign mem_re_o    = accept && produce && row_q[0];
  assign mem_addr_o  = idx;
  assign mem_wdata_o = pair_new;

  `AMDS_ASSERT_NOW(a_rw_excl, !(mem_we_o && mem_re_o), "line write and read in one cycle")
  `AMDS_ASSERT_NOW(a_col_range, col_q <= w_last_q, "column beyond source width")
  `AMDS_ASSERT_NOW(a_row_range, row_q <= h_last_q, "row beyond source height")
  `AMDS_ASSERT_NEXT(a_read_lands, mem_re_o, s1_valid_q && s1_q.use_line, "line read lost")

endmodule

FILE: rtl/core/amds_resolve.sv
module amds_resolve (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s1_valid_i,
  input  amds_pkg::blk_t            s1_i,
  input  amds_pkg::pair_t           line_i,
  output logic                      s1_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [amds_pkg::CH_W-1:0] out_red_o,
  output logic [amds_pkg::CH_W-1:0] out_green_o,
  output logic [amds_pkg::CH_W-1:0] out_blue_o,
  output logic [amds_pkg::CH_W-1:0] out_alpha_o,
  output logic                      frame_end_o
);

  localparam int SW = amds_pkg::SUM_W;

  amds_pkg::pair_t             upper;
  logic [SW-1:0]               t_r, t_g, t_b, t_a;
  logic [2:0]                  t_k;
  logic                        out_valid_q, out_valid_d;
  logic [amds_pkg::CH_W-1:0]   red_q, green_q, blue_q, alpha_q;
  logic                        fend_q;

  // Odd rows add the pair sums that the even row left in the line buffer.
  assign upper = s1_i.use_line ? line_i : '0;
  assign t_r   = SW'(s1_i.sum.r) + SW'(upper.r);
  assign t_g   = SW'(s1_i.sum.g) + SW'(upper.g);
  assign t_b   = SW'(s1_i.sum.b) + SW'(upper.b);
  assign t_a   = SW'(s1_i.sum.a) + SW'(upper.a);
  assign t_k   = 3'(s1_i.sum.k) + 3'(upper.k);

  assign s1_pop_o = s1_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_pop_o) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_pop_o) begin
      red_q   <= amds_pkg::avg(t_r, t_k);
      green_q <= amds_pkg::avg(t_g, t_k);
      blue_q  <= amds_pkg::avg(t_b, t_k);
      alpha_q <= amds_pkg::avg(t_a, t_k);
      fend_q  <= s1_i.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign out_alpha_o = alpha_q;
  assign frame_end_o = fend_q;

endmodule
